// ===== rtl/nirfd_pkg.sv =====
// shared types and constants for the nec infrared frame decoder
`default_nettype none
package nirfd_pkg;

    // raw event codes on the input port
    typedef enum logic [1:0] {
        OP_RISE = 2'd0,
        OP_FALL = 2'd1,
        OP_TICK = 2'd2,
        OP_SCAN = 2'd3
    } t_op;

    // classified commands passed from front to back
    typedef enum logic [2:0] {
        CMD_RISE        = 3'd0,
        CMD_FALL_NONE   = 3'd1,
        CMD_FALL_ZERO   = 3'd2,
        CMD_FALL_ONE    = 3'd3,
        CMD_FALL_REPEAT = 3'd4,
        CMD_FALL_LEADER = 3'd5,
        CMD_TICK        = 3'd6,
        CMD_SCAN        = 3'd7
    } t_cmd;

    // configuration register indexes
    typedef enum logic {
        CFG_DEVICE_ADDRESS = 1'b0,
        CFG_TIMEOUT_TICKS  = 1'b1
    } t_cfg_idx;

    // configuration values seen by the back end
    typedef struct packed {
        logic [7:0] device_address;
        logic [3:0] timeout_ticks;
    } t_cfg;

    // pulse width band limits in microseconds, bounds exclusive
    localparam logic [15:0] ZERO_LO   = 16'd300;
    localparam logic [15:0] ZERO_HI   = 16'd800;
    localparam logic [15:0] ONE_LO    = 16'd1400;
    localparam logic [15:0] ONE_HI    = 16'd1800;
    localparam logic [15:0] REPEAT_LO = 16'd2000;
    localparam logic [15:0] REPEAT_HI = 16'd3000;
    localparam logic [15:0] LEADER_LO = 16'd4200;
    localparam logic [15:0] LEADER_HI = 16'd4700;

    localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd0;
    localparam logic [3:0] TIMEOUT_TICKS_RST  = 4'd14;

    // command queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

endpackage
`default_nettype wire

// ===== rtl/nirfd_front.sv =====
// front end: accepts events and classifies falling-edge pulse widths
`default_nettype none
module nirfd_front (
    input  wire logic           [1:0] i_operation,
    input  wire logic          [15:0] i_pulse_width,
    output nirfd_pkg::t_cmd           o_cmd
);
    import nirfd_pkg::*;

    // width bands are disjoint, so classification needs no state
    always_comb begin
        case (t_op'(i_operation))
            OP_RISE: o_cmd = CMD_RISE;
            OP_FALL: begin
                if (i_pulse_width inside {[ZERO_LO + 16'd1 : ZERO_HI - 16'd1]}) begin
                    o_cmd = CMD_FALL_ZERO;
                end else if (i_pulse_width inside {[ONE_LO + 16'd1 : ONE_HI - 16'd1]}) begin
                    o_cmd = CMD_FALL_ONE;
                end else if (i_pulse_width inside
                             {[REPEAT_LO + 16'd1 : REPEAT_HI - 16'd1]}) begin
                    o_cmd = CMD_FALL_REPEAT;
                end else if (i_pulse_width inside
                             {[LEADER_LO + 16'd1 : LEADER_HI - 16'd1]}) begin
                    o_cmd = CMD_FALL_LEADER;
                end else begin
                    o_cmd = CMD_FALL_NONE;
                end
            end
            OP_TICK: o_cmd = CMD_TICK;
            OP_SCAN: o_cmd = CMD_SCAN;
            default: o_cmd = CMD_FALL_NONE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/nirfd_queue.sv =====
// short command queue between front and back ends
`default_nettype none
module nirfd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  nirfd_pkg::t_cmd      i_push_cmd,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output nirfd_pkg::t_cmd      o_head_cmd
);
    import nirfd_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign o_full     = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_head_cmd = r_mem[r_rd_ptr];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/nirfd_back.sv =====
// back end: decoder state, command execution and result register
`default_nettype none
module nirfd_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  nirfd_pkg::t_cfg  i_cfg,
    input  wire logic        i_cmd_valid,
    input  nirfd_pkg::t_cmd  i_cmd,
    output logic             o_cmd_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic       [7:0] o_key_code,
    output logic       [7:0] o_repeats_out,
    output logic             o_frame_waiting
);
    import nirfd_pkg::*;

    logic        r_leader_seen, n_leader_seen;
    logic        r_rise_seen,   n_rise_seen;
    logic        r_frame_ready, n_frame_ready;
    logic [3:0]  r_idle_ticks,  n_idle_ticks;
    logic [31:0] r_shift_word,  n_shift_word;
    logic [7:0]  r_repeat_cnt,  n_repeat_cnt;
    logic [7:0]  n_key;

    logic        r_out_valid;
    logic [7:0]  r_key_code;
    logic [7:0]  r_repeats_out;
    logic        r_frame_waiting;

    logic [7:0]  addr_byte, addr_inv, cmd_byte, cmd_inv, scan_key;

    // take a command when the result slot is free or being drained
    assign o_cmd_pop = i_cmd_valid && (!r_out_valid || i_out_ready);

    // frame check on scan
    assign addr_byte = r_shift_word[7:0];
    assign addr_inv  = r_shift_word[15:8];
    assign cmd_byte  = r_shift_word[23:16];
    assign cmd_inv   = r_shift_word[31:24];
    assign scan_key  = ((addr_byte == ~addr_inv) && (addr_byte == i_cfg.device_address)
                        && (cmd_byte == ~cmd_inv)) ? cmd_byte : 8'd0;

    // next decoder state for the command at the queue head
    always_comb begin
        n_leader_seen = r_leader_seen;
        n_rise_seen   = r_rise_seen;
        n_frame_ready = r_frame_ready;
        n_idle_ticks  = r_idle_ticks;
        n_shift_word  = r_shift_word;
        n_repeat_cnt  = r_repeat_cnt;
        n_key         = 8'd0;
        case (i_cmd)
            CMD_RISE: n_rise_seen = 1'b1;
            CMD_FALL_NONE: n_rise_seen = 1'b0;
            CMD_FALL_ZERO: begin
                n_rise_seen = 1'b0;
                if (r_rise_seen && r_leader_seen) begin
                    n_shift_word = {1'b0, r_shift_word[31:1]};
                end
            end
            CMD_FALL_ONE: begin
                n_rise_seen = 1'b0;
                if (r_rise_seen && r_leader_seen) begin
                    n_shift_word = {1'b1, r_shift_word[31:1]};
                end
            end
            CMD_FALL_REPEAT: begin
                n_rise_seen = 1'b0;
                if (r_rise_seen && r_leader_seen) begin
                    n_repeat_cnt = r_repeat_cnt + 8'd1;
                    n_idle_ticks = 4'd0;
                end
            end
            CMD_FALL_LEADER: begin
                n_rise_seen = 1'b0;
                if (r_rise_seen && !r_leader_seen) begin
                    n_leader_seen = 1'b1;
                    n_repeat_cnt  = 8'd0;
                end
            end
            CMD_TICK: begin
                if (r_leader_seen) begin
                    n_rise_seen = 1'b0;
                    if (r_idle_ticks == 4'd0) begin
                        n_frame_ready = 1'b1;
                    end
                    if (r_idle_ticks < i_cfg.timeout_ticks) begin
                        n_idle_ticks = r_idle_ticks + 4'd1;
                    end else begin
                        n_leader_seen = 1'b0;
                        n_idle_ticks  = 4'd0;
                    end
                end
            end
            CMD_SCAN: begin
                if (r_frame_ready) begin
                    n_key = scan_key;
                    if ((scan_key == 8'd0) || !r_leader_seen) begin
                        n_frame_ready = 1'b0;
                        n_repeat_cnt  = 8'd0;
                    end
                end
            end
            default: n_rise_seen = r_rise_seen;
        endcase
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_seen <= 1'b0;
            r_rise_seen   <= 1'b0;
            r_frame_ready <= 1'b0;
            r_idle_ticks  <= 4'd0;
            r_shift_word  <= 32'd0;
            r_repeat_cnt  <= 8'd0;
        end else if (o_cmd_pop) begin
            r_leader_seen <= n_leader_seen;
            r_rise_seen   <= n_rise_seen;
            r_frame_ready <= n_frame_ready;
            r_idle_ticks  <= n_idle_ticks;
            r_shift_word  <= n_shift_word;
            r_repeat_cnt  <= n_repeat_cnt;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_key_code      <= n_key;
            r_repeats_out   <= n_repeat_cnt;
            r_frame_waiting <= n_frame_ready;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_code      = r_key_code;
    assign o_repeats_out   = r_repeats_out;
    assign o_frame_waiting = r_frame_waiting;

endmodule
`default_nettype wire

// ===== rtl/nec_ir_frame_decoder.sv =====
// top level of the nec infrared frame decoder with configuration registers
//
// channel   signals                                        direction
// -------   --------------------------------------------   ---------
// input     i_in_valid o_in_ready i_operation i_pulse_width  in
// output    o_out_valid i_out_ready o_key_code o_repeats_out
//           o_frame_waiting                                 out
// config    i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data   in
//
// one request per cycle sustained while results are taken; a request is
// written into the queue, then executed into the result register.
// the four-entry command queue absorbs up to four requests while the
// result side stalls; o_in_ready drops only when the queue is full.
// synchronous active-low reset clears decoder state, queue and registers
// to their defaults; configuration writes are always taken.
`default_nettype none
module nec_ir_frame_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic  [1:0] i_operation,
    input  wire logic [15:0] i_pulse_width,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic       [7:0] o_key_code,
    output logic       [7:0] o_repeats_out,
    output logic             o_frame_waiting,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic  [7:0] i_cfg_data
);
    import nirfd_pkg::*;

    t_cfg  r_cfg;
    t_cmd  front_cmd;
    t_cmd  head_cmd;
    logic  queue_full;
    logic  queue_empty;
    logic  cmd_pop;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= DEVICE_ADDRESS_RST;
            r_cfg.timeout_ticks  <= TIMEOUT_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg_data;
                CFG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= i_cfg_data[3:0];
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    // event classification
    nirfd_front u_front (
        .i_operation   (i_operation),
        .i_pulse_width (i_pulse_width),
        .o_cmd         (front_cmd)
    );

    assign o_in_ready = !queue_full;

    // command queue
    nirfd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in_valid),
        .i_push_cmd (front_cmd),
        .o_full     (queue_full),
        .i_pop      (cmd_pop),
        .o_empty    (queue_empty),
        .o_head_cmd (head_cmd)
    );

    // execution and result register
    nirfd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_cmd_valid     (!queue_empty),
        .i_cmd           (head_cmd),
        .o_cmd_pop       (cmd_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_key_code      (o_key_code),
        .o_repeats_out   (o_repeats_out),
        .o_frame_waiting (o_frame_waiting)
    );

endmodule
`default_nettype wire

// ===== bench/nec_ir_frame_decoder_tb.sv =====
// self-checking testbench for the nec infrared frame decoder
`default_nettype none
module nec_ir_frame_decoder_tb;
    import nirfd_pkg::t_op, nirfd_pkg::OP_RISE, nirfd_pkg::OP_FALL, nirfd_pkg::OP_TICK,
        nirfd_pkg::OP_SCAN, nirfd_pkg::t_cfg_idx, nirfd_pkg::CFG_DEVICE_ADDRESS,
        nirfd_pkg::CFG_TIMEOUT_TICKS;

    // pulse bands in microseconds, bounds exclusive
    localparam int W_ZERO_LO   = 300;
    localparam int W_ZERO_HI   = 800;
    localparam int W_ONE_LO    = 1400;
    localparam int W_ONE_HI    = 1800;
    localparam int W_REPEAT_LO = 2000;
    localparam int W_REPEAT_HI = 3000;
    localparam int W_LEADER_LO = 4200;
    localparam int W_LEADER_HI = 4700;

    localparam int CYCLE_LIMIT = 250000;
    localparam int PHASE_ITEMS = 300;

    typedef enum int {BAND_ZERO, BAND_ONE, BAND_REPEAT, BAND_LEADER} t_band;

    typedef struct packed {
        logic [7:0] key;
        logic [7:0] repeats;
        logic       waiting;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic  [1:0] i_operation = '0;
    logic [15:0] i_pulse_width = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic  [7:0] o_key_code;
    logic  [7:0] o_repeats_out;
    logic        o_frame_waiting;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic  [7:0] i_cfg_data = '0;

    // decoder state mirror and register copies
    logic        ir_leader;
    logic        ir_armed;
    logic        ir_ready;
    logic  [3:0] ir_idle;
    logic [31:0] ir_word;
    logic  [7:0] ir_repeats;
    logic  [7:0] cfg_address;
    logic  [3:0] cfg_timeout;

    t_report report_q[$];
    logic    steady = 1'b0;
    int      ready_hold;
    int      cycle_count = 0;
    int      fault_count = 0;
    int      sent_count = 0;
    int      checked_count = 0;
    int      frames_sent = 0;
    int      keys_decoded = 0;

    nec_ir_frame_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_pulse_width  (i_pulse_width),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_key_code     (o_key_code),
        .o_repeats_out  (o_repeats_out),
        .o_frame_waiting(o_frame_waiting),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nec_ir_frame_decoder verification failed");
            $finish;
        end
    end

    // result side backpressure, a fresh stall drawn after each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ready_hold = 0;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            ready_hold = steady ? 0 : $urandom_range(0, 10);
            i_out_ready <= (ready_hold == 0);
        end else if (ready_hold > 0) begin
            ready_hold--;
            i_out_ready <= (ready_hold == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare every result with the oldest prediction
    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.key = o_key_code;
            got.repeats = o_repeats_out;
            got.waiting = o_frame_waiting;
            if (report_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result with nothing pending: key %0h repeats %0d waiting %0b",
                             got.key, got.repeats, got.waiting);
            end else begin
                want = report_q.pop_front();
                checked_count++;
                if (got !== want) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("result %0d mismatch: key exp %0h got %0h, repeats exp %0d got %0d",
                                 checked_count, want.key, got.key, want.repeats, got.repeats);
                        $display("    waiting exp %0b got %0b", want.waiting, got.waiting);
                    end
                end
            end
        end
    end

    // next decoder state and report for one event
    function automatic t_report decode_event(input t_op op, input logic [15:0] w);
        t_report r;
        logic [7:0] a, na, c, nc;
        r = '0;
        case (op)
            OP_RISE: ir_armed = 1'b1;
            OP_FALL: begin
                if (ir_armed) begin
                    if (ir_leader) begin
                        if (w > W_ZERO_LO && w < W_ZERO_HI) begin
                            ir_word = {1'b0, ir_word[31:1]};
                        end else if (w > W_ONE_LO && w < W_ONE_HI) begin
                            ir_word = {1'b1, ir_word[31:1]};
                        end else if (w > W_REPEAT_LO && w < W_REPEAT_HI) begin
                            ir_repeats = ir_repeats + 8'd1;
                            ir_idle = '0;
                        end
                    end else if (w > W_LEADER_LO && w < W_LEADER_HI) begin
                        ir_leader = 1'b1;
                        ir_repeats = '0;
                    end
                end
                ir_armed = 1'b0;
            end
            OP_TICK: begin
                if (ir_leader) begin
                    ir_armed = 1'b0;
                    if (ir_idle == 4'd0)
                        ir_ready = 1'b1;
                    if (ir_idle < cfg_timeout) begin
                        ir_idle = ir_idle + 4'd1;
                    end else begin
                        ir_leader = 1'b0;
                        ir_idle = '0;
                    end
                end
            end
            OP_SCAN: begin
                if (ir_ready) begin
                    {nc, c, na, a} = ir_word;
                    if (a == ~na && a == cfg_address && c == ~nc)
                        r.key = c;
                    if (r.key == 8'd0 || !ir_leader) begin
                        ir_ready = 1'b0;
                        ir_repeats = '0;
                    end
                end
            end
        endcase
        r.repeats = ir_repeats;
        r.waiting = ir_ready;
        return r;
    endfunction

    function automatic logic [15:0] band_width(input t_band b);
        case (b)
            BAND_ZERO:   return 16'($urandom_range(W_ZERO_LO + 1, W_ZERO_HI - 1));
            BAND_ONE:    return 16'($urandom_range(W_ONE_LO + 1, W_ONE_HI - 1));
            BAND_REPEAT: return 16'($urandom_range(W_REPEAT_LO + 1, W_REPEAT_HI - 1));
            default:     return 16'($urandom_range(W_LEADER_LO + 1, W_LEADER_HI - 1));
        endcase
    endfunction

    // widths for noise: anything, near a band edge, inside a band, or the extremes
    function automatic logic [15:0] noise_width();
        int edges[8] = '{W_ZERO_LO, W_ZERO_HI, W_ONE_LO, W_ONE_HI,
                         W_REPEAT_LO, W_REPEAT_HI, W_LEADER_LO, W_LEADER_HI};
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(edges[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1);
            2: return band_width(t_band'($urandom_range(0, 3)));
            default: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // one request on the event channel, predicted when accepted
    task automatic send_event(input t_op op, input logic [15:0] width);
        int gap;
        t_report r;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_operation <= op;
        i_pulse_width <= width;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        r = decode_event(op, width);
        if (r.key != 8'd0)
            keys_decoded++;
        report_q.push_back(r);
        sent_count++;
    endtask

    task automatic send_pulse(input logic [15:0] width);
        send_event(OP_RISE, 16'($urandom));
        send_event(OP_FALL, width);
    endtask

    task automatic send_noise();
        send_event(t_op'($urandom_range(0, 3)), noise_width());
    endtask

    // leader then up to 32 data bits, lsb first
    task automatic send_frame(input logic [31:0] word, input int bits);
        send_pulse(band_width(BAND_LEADER));
        for (int i = 0; i < bits; i++)
            send_pulse(band_width(word[i] ? BAND_ONE : BAND_ZERO));
        frames_sent++;
    endtask

    // hold off new requests until every result is back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (report_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] data);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS)
            cfg_address = data;
        else
            cfg_timeout = data[3:0];
    endtask

    // directed events at reset values: idle decoder, band edges, stray edges
    task automatic test_band_edges();
        send_event(OP_SCAN, 16'h0000);
        send_event(OP_TICK, 16'hFFFF);
        send_event(OP_FALL, 16'hFFFF);
        send_event(OP_RISE, 16'hFFFF);
        send_event(OP_RISE, 16'h0000);
        send_event(OP_FALL, 16'(W_LEADER_LO));
        send_pulse(16'(W_LEADER_HI));
        send_pulse(16'(W_LEADER_LO + 1));
        send_pulse(16'(W_LEADER_HI - 1));
        send_pulse(16'(W_ZERO_LO + 1));
        send_pulse(16'(W_ONE_HI - 1));
        send_pulse(16'(W_REPEAT_HI - 1));
        send_pulse(16'(W_REPEAT_LO));
        send_event(OP_TICK, 16'h0000);
        send_event(OP_SCAN, 16'hFFFF);
        // a tick drops the pending rise
        send_event(OP_RISE, 16'h5555);
        send_event(OP_TICK, 16'hAAAA);
        send_event(OP_FALL, 16'd1500);
    endtask

    // a good frame followed by enough repeats to wrap the counter
    task automatic test_repeat_wrap();
        logic [7:0] cmd;
        cmd = 8'($urandom_range(1, 255));
        wait_for_results();
        steady = 1'b1;
        send_frame({~cmd, cmd, ~cfg_address, cfg_address}, 32);
        repeat (257) send_pulse(band_width(BAND_REPEAT));
        send_event(OP_TICK, 16'($urandom));
        send_event(OP_SCAN, 16'($urandom));
        steady = 1'b0;
    endtask

    // one frame with random content and what follows it on the air
    task automatic send_frame_session();
        logic [7:0] addr, cmd;
        logic [31:0] word;
        int n;
        int pick;
        addr = ($urandom_range(0, 4) != 0) ? cfg_address : 8'($urandom);
        cmd = ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom);
        word = {~cmd, cmd, ~addr, addr};
        if ($urandom_range(0, 6) == 0)
            word[$urandom_range(0, 31)] ^= 1'b1;
        if ($urandom_range(0, 5) == 0)
            send_event(OP_SCAN, 16'($urandom));
        send_frame(word, 32);
        n = $urandom_range(1, 8);
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_event(OP_TICK, 16'($urandom));
            else if (pick < 65)
                send_pulse(band_width(BAND_REPEAT));
            else if (pick < 85)
                send_event(OP_SCAN, 16'($urandom));
            else
                send_noise();
        end
        // sometimes age the frame past the timeout
        if ($urandom_range(0, 3) == 0)
            repeat (int'(cfg_timeout) + 2) send_event(OP_TICK, 16'($urandom));
        send_event(OP_SCAN, 16'($urandom));
    endtask

    task automatic test_random_traffic(input int quota);
        int start;
        int pick;
        start = sent_count;
        while (sent_count - start < quota) begin
            steady = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame_session();
            end else if (pick < 82) begin
                // frame cut short, then junk
                send_frame(32'($urandom), $urandom_range(0, 31));
                repeat ($urandom_range(1, 4)) send_noise();
            end else begin
                repeat ($urandom_range(1, 8)) send_noise();
            end
            if ($urandom_range(0, 29) == 0)
                wait_for_results();
        end
        steady = 1'b0;
    endtask

    initial begin
        ir_leader = 1'b0;
        ir_armed = 1'b0;
        ir_ready = 1'b0;
        ir_idle = '0;
        ir_word = '0;
        ir_repeats = '0;
        cfg_address = 8'd0;
        cfg_timeout = 4'd14;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_band_edges();
        test_random_traffic(PHASE_ITEMS);

        write_reg(CFG_DEVICE_ADDRESS, 8'hFF);
        write_reg(CFG_TIMEOUT_TICKS, 8'd15);
        test_repeat_wrap();
        test_random_traffic(PHASE_ITEMS);

        write_reg(CFG_DEVICE_ADDRESS, 8'h00);
        write_reg(CFG_TIMEOUT_TICKS, 8'd1);
        test_random_traffic(PHASE_ITEMS);

        repeat (2) begin
            write_reg(CFG_TIMEOUT_TICKS, 8'($urandom_range(1, 15)));
            write_reg(CFG_DEVICE_ADDRESS, 8'($urandom));
            test_random_traffic(PHASE_ITEMS);
        end

        wait_for_results();
        repeat (8) @(posedge i_clk);
        $display("covered %0d events, %0d results checked, %0d frames, %0d keys decoded",
                 sent_count, checked_count, frames_sent, keys_decoded);
        $display("address 00/ff/random, timeout 1/14/15/random, repeat count wrapped");
        if (fault_count == 0 && report_q.size() == 0) begin
            $display("nec_ir_frame_decoder verification clean");
        end else begin
            $display("nec_ir_frame_decoder verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
